// ===== rtl/least_squares_line_fit_core_macros.svh =====
// Assertion macros for the least-squares line fit core.
// Included by the modules that carry concurrent checks; no other dependency.
`ifndef LEAST_SQUARES_LINE_FIT_CORE_MACROS_SVH
`define LEAST_SQUARES_LINE_FIT_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define LSQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define LSQ_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define LSQ_ASSERT(lbl, clk, rst_n, prop)
`define LSQ_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== rtl/lsq_pkg.sv =====
// Shared constants, command/status types and opcodes of the line fit core.
// No dependencies; used by lsq_ctrl, lsq_datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package lsq_pkg;
  localparam int MAX_PAIRS      = 1024;
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 16;
  localparam int CORR_FRAC_BITS = 30;

  localparam int IN_W    = 24;
  localparam int CNT_W   = 11;
  localparam int SUM_W   = 34;
  localparam int SQ_W    = 58;
  localparam int CORR_W  = 32;
  localparam int SLOPE_W = 41;
  localparam int ICPT_W  = 64;
  localparam int STAT_W  = 3;
  localparam int WW      = 160;
  localparam int ITER_W  = $clog2(WW);

  localparam int S_TDATA_W = 48;
  localparam int M_FIELD_W = CORR_W + SLOPE_W + ICPT_W + CNT_W;
  localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

  localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd1;
  localparam logic [STAT_W-1:0] ST_XCONST = 3'd2;
  localparam logic [STAT_W-1:0] ST_YCONST = 3'd3;
  localparam logic [STAT_W-1:0] ST_OVFL   = 3'd4;

  typedef enum logic [3:0] {
    OP_NOP, OP_MUL, OP_DIV, OP_SQRT, OP_DIFF_SXY, OP_DIFF_SXX, OP_DIFF_SYY,
    OP_DIFF_NUM, OP_STAT, OP_SET_SLOPE, OP_SET_ICPT, OP_SET_CORR
  } op_e;

  typedef enum logic [3:0] {
    SEL_N, SEL_SX, SEL_SY, SEL_SXX_S, SEL_SYY_S, SEL_SXY_S, SEL_SXX, SEL_SYY,
    SEL_SXY_SH_COEF, SEL_SXY_SH_CORR, SEL_NUM_SH_COEF, SEL_T1, SEL_ROOT
  } sel_e;

  typedef struct packed {
    logic acc;
    logic clr;
    logic start;
    op_e  op;
    sel_e a_sel;
    sel_e b_sel;
    logic dst_t2;
  } cmd_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [STAT_W-1:0] code;
    logic              cnt_zero;
  } stat_t;
endpackage
`default_nettype wire

// ===== rtl/least_squares_line_fit_core.sv =====
// Top level of the least-squares line fit core with Pearson correlation.
// Depends on lsq_pkg, lsq_ctrl and lsq_datapath.
//
//  channel  | dir | tdata                                   | tuser  | tlast
//  s_axis   | in  | x_value[23:0], y_value[47:24]           | -      | last
//  m_axis   | out | corr, slope, intercept, pair_count      | status | -
//
// Pairs without last are taken at one pair per cycle, back to back. A pair
// with last starts the fit, which runs on one bit-serial shift-add multiplier,
// one restoring divider (160 steps) and one square-root unit (80 steps). The
// sequencer starts each step and waits for its done before it moves on. With
// an empty set or constant x the fit stops after the status step, and with
// constant y it stops after the intercept step.
// Reset clears the sums and the sequencer; the input holds off while the fit
// runs and while the result beat is waiting, and the sums clear when that beat
// is taken.
`timescale 1ns / 1ps
`default_nettype none
module least_squares_line_fit_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // x_value [23:0], y_value [47:24]
  input  wire logic [lsq_pkg::S_TDATA_W-1:0]     s_axis_tdata_i,
  input  wire logic                              s_axis_tlast_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // correlation [31:0], slope [72:32], intercept [136:73], pair_count [147:137]
  output logic [lsq_pkg::M_TDATA_W-1:0]          m_axis_tdata_o,
  // status [2:0]
  output logic [lsq_pkg::STAT_W-1:0]             m_axis_tuser_o
);
  lsq_pkg::cmd_t  cmd;
  lsq_pkg::stat_t st;
  logic [lsq_pkg::CORR_W-1:0]  corr;
  logic [lsq_pkg::SLOPE_W-1:0] slope;
  logic [lsq_pkg::ICPT_W-1:0]  icpt;
  logic [lsq_pkg::CNT_W-1:0]   cnt;

  lsq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_last_i   (s_axis_tlast_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd),
    .st_i        (st)
  );

  lsq_datapath u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .st_o    (st),
    .x_i     (s_axis_tdata_i[lsq_pkg::IN_W-1:0]),
    .y_i     (s_axis_tdata_i[2*lsq_pkg::IN_W-1:lsq_pkg::IN_W]),
    .corr_o  (corr),
    .slope_o (slope),
    .icpt_o  (icpt),
    .cnt_o   (cnt),
    .code_o  (m_axis_tuser_o)
  );

  // pack the result beat, first field lowest, zero pad to whole bytes
  assign m_axis_tdata_o = {{(lsq_pkg::M_TDATA_W - lsq_pkg::M_FIELD_W){1'b0}},
                           cnt, icpt, slope, corr};
endmodule
`default_nettype wire

// ===== rtl/lsq_ctrl.sv =====
// Sequencer of the line fit core: accumulate, fit steps, result hand-off.
// Depends on lsq_pkg and least_squares_line_fit_core_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "least_squares_line_fit_core_macros.svh"
module lsq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_last_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output lsq_pkg::cmd_t      cmd_o,
  input  wire lsq_pkg::stat_t st_i
);
  localparam logic [4:0] S_IDLE = 5'd0,  S_M1 = 5'd1,  S_M2 = 5'd2,  S_D1 = 5'd3,
                         S_M3   = 5'd4,  S_M4 = 5'd5,  S_D2 = 5'd6,  S_M5 = 5'd7,
                         S_M6   = 5'd8,  S_D3 = 5'd9,  S_ST = 5'd10, S_V1 = 5'd11,
                         S_SL   = 5'd12, S_M7 = 5'd13, S_M8 = 5'd14, S_D4 = 5'd15,
                         S_V2   = 5'd16, S_IC = 5'd17, S_M9 = 5'd18, S_SQ = 5'd19,
                         S_V3   = 5'd20, S_CO = 5'd21, S_OUT = 5'd22;

  logic [4:0] state_q, state_d, step_next;
  logic       issued_q, issued_d;
  lsq_pkg::op_e  op;
  lsq_pkg::sel_e a_sel, b_sel;
  logic       dst_t2;

  always_comb begin
    op = lsq_pkg::OP_NOP; a_sel = lsq_pkg::SEL_N; b_sel = lsq_pkg::SEL_N;
    dst_t2 = 1'b0; step_next = S_IDLE;
    unique case (state_q)
      S_M1: begin op = lsq_pkg::OP_MUL; a_sel = lsq_pkg::SEL_N;  b_sel = lsq_pkg::SEL_SXY_S;
        step_next = S_M2; end
      S_M2: begin op = lsq_pkg::OP_MUL; a_sel = lsq_pkg::SEL_SX; b_sel = lsq_pkg::SEL_SY;
        dst_t2 = 1'b1; step_next = S_D1; end
      S_D1: begin op = lsq_pkg::OP_DIFF_SXY; step_next = S_M3; end
      S_M3: begin op = lsq_pkg::OP_MUL; a_sel = lsq_pkg::SEL_N;  b_sel = lsq_pkg::SEL_SXX_S;
        step_next = S_M4; end
      S_M4: begin op = lsq_pkg::OP_MUL; a_sel = lsq_pkg::SEL_SX; b_sel = lsq_pkg::SEL_SX;
        dst_t2 = 1'b1; step_next = S_D2; end
      S_D2: begin op = lsq_pkg::OP_DIFF_SXX; step_next = S_M5; end
      S_M5: begin op = lsq_pkg::OP_MUL; a_sel = lsq_pkg::SEL_N;  b_sel = lsq_pkg::SEL_SYY_S;
        step_next = S_M6; end
      S_M6: begin op = lsq_pkg::OP_MUL; a_sel = lsq_pkg::SEL_SY; b_sel = lsq_pkg::SEL_SY;
        dst_t2 = 1'b1; step_next = S_D3; end
      S_D3: begin op = lsq_pkg::OP_DIFF_SYY; step_next = S_ST; end
      S_ST: begin op = lsq_pkg::OP_STAT; step_next = S_V1; end
      S_V1: begin op = lsq_pkg::OP_DIV; a_sel = lsq_pkg::SEL_SXY_SH_COEF;
        b_sel = lsq_pkg::SEL_SXX; step_next = S_SL; end
      S_SL: begin op = lsq_pkg::OP_SET_SLOPE; step_next = S_M7; end
      S_M7: begin op = lsq_pkg::OP_MUL; a_sel = lsq_pkg::SEL_SY; b_sel = lsq_pkg::SEL_SXX_S;
        step_next = S_M8; end
      S_M8: begin op = lsq_pkg::OP_MUL; a_sel = lsq_pkg::SEL_SX; b_sel = lsq_pkg::SEL_SXY_S;
        dst_t2 = 1'b1; step_next = S_D4; end
      S_D4: begin op = lsq_pkg::OP_DIFF_NUM; step_next = S_V2; end
      S_V2: begin op = lsq_pkg::OP_DIV; a_sel = lsq_pkg::SEL_NUM_SH_COEF;
        b_sel = lsq_pkg::SEL_SXX; step_next = S_IC; end
      S_IC: begin op = lsq_pkg::OP_SET_ICPT; step_next = S_M9; end
      S_M9: begin op = lsq_pkg::OP_MUL; a_sel = lsq_pkg::SEL_SXX; b_sel = lsq_pkg::SEL_SYY;
        step_next = S_SQ; end
      S_SQ: begin op = lsq_pkg::OP_SQRT; a_sel = lsq_pkg::SEL_T1; step_next = S_V3; end
      S_V3: begin op = lsq_pkg::OP_DIV; a_sel = lsq_pkg::SEL_SXY_SH_CORR;
        b_sel = lsq_pkg::SEL_ROOT; step_next = S_CO; end
      S_CO: begin op = lsq_pkg::OP_SET_CORR; step_next = S_OUT; end
      default: begin op = lsq_pkg::OP_NOP; step_next = S_IDLE; end
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    cmd_o        = '0;
    cmd_o.op     = op;
    cmd_o.a_sel  = a_sel;
    cmd_o.b_sel  = b_sel;
    cmd_o.dst_t2 = dst_t2;
    cmd_o.acc    = in_ready_o && in_valid_i;
    cmd_o.clr    = out_valid_o && out_ready_i;
    cmd_o.start  = (op != lsq_pkg::OP_NOP) && !issued_q;
    state_d      = state_q;
    issued_d     = issued_q;
    if (cmd_o.start) issued_d = 1'b1;
    priority if (state_q == S_IDLE) begin
      if (cmd_o.acc && in_last_i) state_d = S_M1;
    end else if (state_q == S_OUT) begin
      if (cmd_o.clr) state_d = S_IDLE;
    end else if (issued_q && st_i.done) begin
      issued_d = 1'b0;
      state_d  = step_next;
      // skip the fit when x is constant or the set is empty, skip r when y is constant
      if (state_q == S_ST && (st_i.code == lsq_pkg::ST_EMPTY ||
                              st_i.code == lsq_pkg::ST_XCONST)) state_d = S_OUT;
      if (state_q == S_IC && st_i.code == lsq_pkg::ST_YCONST) state_d = S_OUT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
    end
  end

  `LSQ_ASSERT_NEVER(a_no_overlap, clk_i, rst_ni, in_ready_o && out_valid_o)
  `LSQ_ASSERT(a_start_idle_unit, clk_i, rst_ni, cmd_o.start |-> !st_i.busy)
  `LSQ_ASSERT(a_clear_after_out, clk_i, rst_ni, cmd_o.clr |=> st_i.cnt_zero)
endmodule
`default_nettype wire

// ===== rtl/lsq_datapath.sv =====
// Datapath of the line fit core: running sums, bit-serial multiply, divide
// and square root over one shared set of wide registers. Depends on lsq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lsq_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire lsq_pkg::cmd_t               cmd_i,
  output lsq_pkg::stat_t                   st_o,
  input  wire logic [lsq_pkg::IN_W-1:0]    x_i,
  input  wire logic [lsq_pkg::IN_W-1:0]    y_i,
  output logic [lsq_pkg::CORR_W-1:0]       corr_o,
  output logic [lsq_pkg::SLOPE_W-1:0]      slope_o,
  output logic [lsq_pkg::ICPT_W-1:0]       icpt_o,
  output logic [lsq_pkg::CNT_W-1:0]        cnt_o,
  output logic [lsq_pkg::STAT_W-1:0]       code_o
);
  localparam int WW = lsq_pkg::WW;
  localparam int SB = lsq_pkg::SAMPLE_BITS;
  localparam logic [63:0] SLOPE_MAX = (64'd1 << (lsq_pkg::SLOPE_W - 1)) - 64'd1;
  localparam logic [63:0] CORR_MAX  = 64'd1 << lsq_pkg::CORR_FRAC_BITS;
  localparam logic [63:0] ICPT_MAX  = {1'b0, {63{1'b1}}};

  // running sums
  logic [lsq_pkg::CNT_W-1:0] cnt_q;
  logic [lsq_pkg::SUM_W-1:0] sx_q, sy_q;
  logic [lsq_pkg::SQ_W-1:0]  sxx_s_q, syy_s_q, sxy_s_q;
  logic                      ovf_q;
  logic [SB-1:0]             xs, ys;
  logic [2*SB-1:0]           pxx, pyy, pxy;
  logic                      full;

  assign xs   = x_i[SB-1:0];
  assign ys   = y_i[SB-1:0];
  assign pxx  = xs * xs;
  assign pyy  = ys * ys;
  assign pxy  = xs * ys;
  assign full = (cnt_q == lsq_pkg::CNT_W'(lsq_pkg::MAX_PAIRS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; sx_q <= '0; sy_q <= '0;
      sxx_s_q <= '0; syy_s_q <= '0; sxy_s_q <= '0; ovf_q <= 1'b0;
    end else if (cmd_i.clr) begin
      cnt_q <= '0; sx_q <= '0; sy_q <= '0;
      sxx_s_q <= '0; syy_s_q <= '0; sxy_s_q <= '0; ovf_q <= 1'b0;
    end else if (cmd_i.acc) begin
      if (full) begin
        ovf_q <= 1'b1;
      end else begin
        cnt_q   <= cnt_q + 1'b1;
        sx_q    <= sx_q + lsq_pkg::SUM_W'(xs);
        sy_q    <= sy_q + lsq_pkg::SUM_W'(ys);
        sxx_s_q <= sxx_s_q + lsq_pkg::SQ_W'(pxx);
        syy_s_q <= syy_s_q + lsq_pkg::SQ_W'(pyy);
        sxy_s_q <= sxy_s_q + lsq_pkg::SQ_W'(pxy);
      end
    end
  end

  // fit registers
  logic [WW-1:0] t1_q, t2_q, sxx_q, syy_q, sxy_q, num_q, q_q, root_q;
  logic          nsxy_q, neg_q;
  logic [lsq_pkg::STAT_W-1:0] code_q;
  logic [lsq_pkg::CORR_W-1:0] corr_q;
  logic [lsq_pkg::SLOPE_W-1:0] slope_q;
  logic [lsq_pkg::ICPT_W-1:0] icpt_q;

  function automatic logic [WW-1:0] pick(input lsq_pkg::sel_e s, input logic [WW-1:0] n,
      input logic [WW-1:0] sx, input logic [WW-1:0] sy, input logic [WW-1:0] sxxs,
      input logic [WW-1:0] syys, input logic [WW-1:0] sxys, input logic [WW-1:0] sxx,
      input logic [WW-1:0] syy, input logic [WW-1:0] sxy, input logic [WW-1:0] num,
      input logic [WW-1:0] t1, input logic [WW-1:0] root);
    logic [WW-1:0] v;
    unique case (s)
      lsq_pkg::SEL_N:           v = n;
      lsq_pkg::SEL_SX:          v = sx;
      lsq_pkg::SEL_SY:          v = sy;
      lsq_pkg::SEL_SXX_S:       v = sxxs;
      lsq_pkg::SEL_SYY_S:       v = syys;
      lsq_pkg::SEL_SXY_S:       v = sxys;
      lsq_pkg::SEL_SXX:         v = sxx;
      lsq_pkg::SEL_SYY:         v = syy;
      lsq_pkg::SEL_SXY_SH_COEF: v = sxy << lsq_pkg::COEF_FRAC_BITS;
      lsq_pkg::SEL_SXY_SH_CORR: v = sxy << lsq_pkg::CORR_FRAC_BITS;
      lsq_pkg::SEL_NUM_SH_COEF: v = num << lsq_pkg::COEF_FRAC_BITS;
      lsq_pkg::SEL_T1:          v = t1;
      lsq_pkg::SEL_ROOT:        v = root;
      default:                  v = '0;
    endcase
    return v;
  endfunction

  // sign and magnitude to two's complement, magnitude clamped
  function automatic logic [63:0] sat64(input logic neg, input logic [WW-1:0] q,
                                        input logic [63:0] posmax);
    logic [63:0] lim, mag;
    lim = neg ? posmax + 64'd1 : posmax;
    mag = (q > WW'(lim)) ? lim : q[63:0];
    return neg ? 64'd0 - mag : mag;
  endfunction

  logic [WW-1:0] opa, opb;
  assign opa = pick(cmd_i.a_sel, WW'(cnt_q), WW'(sx_q), WW'(sy_q), WW'(sxx_s_q),
                    WW'(syy_s_q), WW'(sxy_s_q), sxx_q, syy_q, sxy_q, num_q, t1_q, root_q);
  assign opb = pick(cmd_i.b_sel, WW'(cnt_q), WW'(sx_q), WW'(sy_q), WW'(sxx_s_q),
                    WW'(syy_s_q), WW'(sxy_s_q), sxx_q, syy_q, sxy_q, num_q, t1_q, root_q);

  // iterative unit
  logic          busy_q, done_q, dst_q;
  lsq_pkg::op_e  run_q;
  logic [WW-1:0] ua_q, ub_q, qq_q, bitv_q;
  logic [WW:0]   acc_q;
  logic [lsq_pkg::ITER_W-1:0] it_q;

  logic          lt12;
  logic [WW-1:0] d12;
  logic [WW:0]   rem_sh;
  logic          qbit;
  logic [WW-1:0] sq_t;
  logic          sq_ge;
  logic [63:0]   sat_v;
  logic          sat_neg;
  logic [63:0]   sat_max;

  assign lt12   = t1_q < t2_q;
  assign d12    = lt12 ? t2_q - t1_q : t1_q - t2_q;
  assign rem_sh = {acc_q[WW-1:0], ub_q[WW-1]};
  assign qbit   = rem_sh >= {1'b0, ua_q};
  assign sq_t   = qq_q + bitv_q;
  assign sq_ge  = ua_q >= sq_t;

  always_comb begin
    sat_neg = 1'b0;
    sat_max = ICPT_MAX;
    unique case (cmd_i.op)
      lsq_pkg::OP_SET_SLOPE: begin sat_neg = nsxy_q; sat_max = SLOPE_MAX; end
      lsq_pkg::OP_SET_CORR:  begin sat_neg = nsxy_q; sat_max = CORR_MAX;  end
      default:               begin sat_neg = neg_q;  sat_max = ICPT_MAX;  end
    endcase
    sat_v = sat64(sat_neg && (q_q != '0), q_q, sat_max);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      run_q  <= lsq_pkg::OP_NOP;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        unique case (cmd_i.op)
          lsq_pkg::OP_MUL, lsq_pkg::OP_DIV, lsq_pkg::OP_SQRT: busy_q <= 1'b1;
          default: done_q <= 1'b1;
        endcase
        run_q <= cmd_i.op;
      end else if (busy_q) begin
        unique case (run_q)
          lsq_pkg::OP_MUL: if (ub_q == '0) begin busy_q <= 1'b0; done_q <= 1'b1; end
          default: if (it_q == '0) begin busy_q <= 1'b0; done_q <= 1'b1; end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      dst_q <= cmd_i.dst_t2;
      unique case (cmd_i.op)
        lsq_pkg::OP_MUL: begin ua_q <= opa; ub_q <= opb; acc_q <= '0; end
        lsq_pkg::OP_DIV: begin
          ua_q <= opb; ub_q <= opa; acc_q <= '0; qq_q <= '0;
          it_q <= lsq_pkg::ITER_W'(WW - 1);
        end
        lsq_pkg::OP_SQRT: begin
          ua_q <= opa; qq_q <= '0; bitv_q <= WW'(1) << (WW - 2);
          it_q <= lsq_pkg::ITER_W'(WW / 2 - 1);
        end
        lsq_pkg::OP_DIFF_SXY: begin sxy_q <= d12; nsxy_q <= lt12; end
        lsq_pkg::OP_DIFF_SXX: sxx_q <= lt12 ? '0 : d12;
        lsq_pkg::OP_DIFF_SYY: syy_q <= lt12 ? '0 : d12;
        lsq_pkg::OP_DIFF_NUM: begin num_q <= d12; neg_q <= lt12; end
        lsq_pkg::OP_STAT: begin
          corr_q <= '0; slope_q <= '0; icpt_q <= '0;
          priority if (cnt_q == '0) code_q <= lsq_pkg::ST_EMPTY;
          else if (sxx_q == '0)     code_q <= lsq_pkg::ST_XCONST;
          else if (syy_q == '0)     code_q <= lsq_pkg::ST_YCONST;
          else if (ovf_q)           code_q <= lsq_pkg::ST_OVFL;
          else                      code_q <= lsq_pkg::ST_OK;
        end
        lsq_pkg::OP_SET_SLOPE: slope_q <= sat_v[lsq_pkg::SLOPE_W-1:0];
        lsq_pkg::OP_SET_ICPT:  icpt_q  <= sat_v;
        lsq_pkg::OP_SET_CORR:  corr_q  <= sat_v[lsq_pkg::CORR_W-1:0];
        default: ;
      endcase
    end else if (busy_q) begin
      unique case (run_q)
        lsq_pkg::OP_MUL: begin
          if (ub_q == '0) begin
            if (dst_q) t2_q <= acc_q[WW-1:0];
            else       t1_q <= acc_q[WW-1:0];
          end else begin
            if (ub_q[0]) acc_q <= {1'b0, acc_q[WW-1:0] + ua_q};
            ua_q <= ua_q << 1;
            ub_q <= ub_q >> 1;
          end
        end
        lsq_pkg::OP_DIV: begin
          acc_q <= qbit ? rem_sh - {1'b0, ua_q} : rem_sh;
          qq_q  <= {qq_q[WW-2:0], qbit};
          ub_q  <= ub_q << 1;
          it_q  <= it_q - 1'b1;
          // divide by zero yields zero
          if (it_q == '0) q_q <= (ua_q == '0) ? '0 : {qq_q[WW-2:0], qbit};
        end
        default: begin
          if (sq_ge) begin
            ua_q <= ua_q - sq_t;
            qq_q <= (qq_q >> 1) + bitv_q;
          end else begin
            qq_q <= qq_q >> 1;
          end
          bitv_q <= bitv_q >> 2;
          it_q   <= it_q - 1'b1;
          if (it_q == '0) root_q <= sq_ge ? (qq_q >> 1) + bitv_q : qq_q >> 1;
        end
      endcase
    end
  end

  assign st_o.busy     = busy_q;
  assign st_o.done     = done_q;
  assign st_o.code     = code_q;
  assign st_o.cnt_zero = (cnt_q == '0);
  assign corr_o  = corr_q;
  assign slope_o = slope_q;
  assign icpt_o  = icpt_q;
  assign cnt_o   = cnt_q;
  assign code_o  = code_q;
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for least_squares_line_fit_core: feeds sets of (x, y) beats,
// predicts each fit result with exact wide integer sums, and compares every result beat.
// Depends on lsq_pkg and the RTL of the core.
`timescale 1ns / 1ps
module tb_top;
  localparam int RUN_LIMIT = 3_000_000;
  localparam int TAIL_CYCLES = 200;
  localparam logic [23:0] SMAX = 24'hFF_FFFF;

  typedef struct {
    logic [23:0] x;
    logic [23:0] y;
    logic        last;
  } pair_t;

  typedef struct packed {
    logic [lsq_pkg::CORR_W-1:0]  corr;
    logic [lsq_pkg::SLOPE_W-1:0] slope;
    logic [lsq_pkg::ICPT_W-1:0]  icpt;
    logic [lsq_pkg::CNT_W-1:0]   cnt;
    logic [lsq_pkg::STAT_W-1:0]  st;
  } fit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [lsq_pkg::S_TDATA_W-1:0] s_axis_tdata_i = '0;
  logic s_axis_tlast_i = 1'b0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [lsq_pkg::M_TDATA_W-1:0] m_axis_tdata_o;
  logic [lsq_pkg::STAT_W-1:0] m_axis_tuser_o;

  pair_t pending_pairs[$];
  fit_t  expected_fits[$];
  int    errors = 0;
  int    cycles = 0;
  bit    calm = 1'b0;   // no idling in the closing stretch

  // predictor state
  int unsigned acc_cnt = 0;
  logic [63:0] acc_sx = '0, acc_sy = '0, acc_sxx = '0, acc_syy = '0, acc_sxy = '0;
  bit acc_ovf = 1'b0;

  least_squares_line_fit_core u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tlast_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [159:0] floor_sqrt(logic [159:0] a);
    logic [161:0] root;
    logic [161:0] cand;
    root = '0;
    for (int i = 79; i >= 0; i--) begin
      cand = root | (162'd1 << i);
      if (cand * cand <= {2'b00, a}) root = cand;
    end
    return root[159:0];
  endfunction

  // Clamp a sign/magnitude quotient into two's complement, to posmax or -(posmax+1).
  function automatic logic [63:0] clamp_signed(bit neg, logic [159:0] q, logic [63:0] posmax);
    logic [63:0] mag;
    mag = (q[159:64] != '0) ? '1 : q[63:0];
    if (neg) begin
      if (mag > posmax) mag = posmax + 64'd1;
      return 64'd0 - mag;
    end
    return (mag > posmax) ? posmax : mag;
  endfunction

  // Fold one accepted pair into the sums; on last, return the fit and clear.
  function automatic bit fold_pair(pair_t p, output fit_t f);
    logic [159:0] n, t1, t2, dxy, dxx, dyy, num, q, root;
    bit neg_xy, neg_i;
    logic [2:0] st;
    if (acc_cnt < lsq_pkg::MAX_PAIRS) begin
      acc_cnt++;
      acc_sx  += 64'(p.x);
      acc_sy  += 64'(p.y);
      acc_sxx += 64'(p.x) * 64'(p.x);
      acc_syy += 64'(p.y) * 64'(p.y);
      acc_sxy += 64'(p.x) * 64'(p.y);
    end else begin
      acc_ovf = 1'b1;
    end
    if (!p.last) return 1'b0;
    n = 160'(acc_cnt);
    t1 = n * 160'(acc_sxy); t2 = 160'(acc_sx) * 160'(acc_sy);
    neg_xy = t1 < t2;
    dxy = neg_xy ? t2 - t1 : t1 - t2;
    t1 = n * 160'(acc_sxx); t2 = 160'(acc_sx) * 160'(acc_sx);
    dxx = (t1 < t2) ? '0 : t1 - t2;
    t1 = n * 160'(acc_syy); t2 = 160'(acc_sy) * 160'(acc_sy);
    dyy = (t1 < t2) ? '0 : t1 - t2;
    if (acc_cnt == 0)    st = lsq_pkg::ST_EMPTY;
    else if (dxx == '0)  st = lsq_pkg::ST_XCONST;
    else if (dyy == '0)  st = lsq_pkg::ST_YCONST;
    else if (acc_ovf)    st = lsq_pkg::ST_OVFL;
    else                 st = lsq_pkg::ST_OK;
    f = '0;
    if (st != lsq_pkg::ST_EMPTY && st != lsq_pkg::ST_XCONST) begin
      q = (dxy << lsq_pkg::COEF_FRAC_BITS) / dxx;
      f.slope = lsq_pkg::SLOPE_W'(clamp_signed(neg_xy, q, (64'd1 << 40) - 64'd1));
      t1 = 160'(acc_sy) * 160'(acc_sxx); t2 = 160'(acc_sx) * 160'(acc_sxy);
      neg_i = t1 < t2;
      num = neg_i ? t2 - t1 : t1 - t2;
      q = (num << lsq_pkg::COEF_FRAC_BITS) / dxx;
      f.icpt = clamp_signed(neg_i, q, 64'h7FFF_FFFF_FFFF_FFFF);
      if (st != lsq_pkg::ST_YCONST) begin
        root = floor_sqrt(dxx * dyy);
        q = (dxy << lsq_pkg::CORR_FRAC_BITS) / root;
        f.corr = lsq_pkg::CORR_W'(clamp_signed(neg_xy, q,
                                               64'd1 << lsq_pkg::CORR_FRAC_BITS));
      end
    end
    f.cnt = lsq_pkg::CNT_W'(acc_cnt);
    f.st = st;
    acc_cnt = 0; acc_sx = '0; acc_sy = '0; acc_sxx = '0; acc_syy = '0; acc_sxy = '0;
    acc_ovf = 1'b0;
    return 1'b1;
  endfunction

  task automatic add_pair(logic [23:0] x, logic [23:0] y, logic last);
    pair_t p;
    p.x = x; p.y = y; p.last = last;
    pending_pairs.push_back(p);
  endtask

  // One random set: mixes wide noise, narrow ranges, constant axes and near-linear data.
  task automatic add_random_set(int len);
    int shape;
    logic [23:0] x0, y0, span, x, y;
    int slope_k;
    shape = int'($urandom_range(0, 5));
    x0 = 24'($urandom); y0 = 24'($urandom);
    span = 24'($urandom_range(1, 255));
    slope_k = int'($urandom_range(0, 8)) - 4;
    for (int i = 0; i < len; i++) begin
      case (shape)
        0, 1: begin x = 24'($urandom); y = 24'($urandom); end
        2: begin x = x0 + 24'($urandom_range(0, span)); y = y0 + 24'($urandom_range(0, span)); end
        3: begin x = x0; y = 24'($urandom); end
        4: begin x = 24'($urandom); y = y0; end
        default: begin
          x = 24'($urandom_range(0, 65535));
          y = 24'(32'sd8_000_000 + slope_k * int'(x) + int'($urandom_range(0, 15)));
        end
      endcase
      add_pair(x, y, i == len - 1);
    end
  endtask

  // Source side: hold a beat until taken, idle in short random bursts.
  int src_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    fit_t f;
    pair_t p;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        p.x = s_axis_tdata_i[23:0];
        p.y = s_axis_tdata_i[47:24];
        p.last = s_axis_tlast_i;
        if (fold_pair(p, f)) expected_fits.push_back(f);
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid_i <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          src_gap <= int'($urandom_range(0, 2));
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          p = pending_pairs.pop_front();
          s_axis_tdata_i <= {p.y, p.x};
          s_axis_tlast_i <= p.last;
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Sink side: stall in random bursts, compare each result beat with the oldest fit.
  int snk_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    fit_t want, got;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.corr  = m_axis_tdata_o[31:0];
        got.slope = m_axis_tdata_o[72:32];
        got.icpt  = m_axis_tdata_o[136:73];
        got.cnt   = m_axis_tdata_o[147:137];
        got.st    = m_axis_tuser_o;
        if (expected_fits.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat %h", $realtime, got);
        end else begin
          want = expected_fits.pop_front();
          if (got.corr !== want.corr) begin
            errors++;
            $display("%0t: correlation exp %h got %h", $realtime, want.corr, got.corr);
          end
          if (got.slope !== want.slope) begin
            errors++;
            $display("%0t: slope exp %h got %h", $realtime, want.slope, got.slope);
          end
          if (got.icpt !== want.icpt) begin
            errors++;
            $display("%0t: intercept exp %h got %h", $realtime, want.icpt, got.icpt);
          end
          if (got.cnt !== want.cnt) begin
            errors++;
            $display("%0t: pair_count exp %0d got %0d", $realtime, want.cnt, got.cnt);
          end
          if (got.st !== want.st) begin
            errors++;
            $display("%0t: status exp %0d got %0d", $realtime, want.st, got.st);
          end
        end
      end
      if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        m_axis_tready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        snk_gap <= int'($urandom_range(0, 2));
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("least_squares_line_fit_core regression: fail");
      $finish;
    end
  end

  initial begin
    int total;
    // directed: single pair, extremes, perfect +/- lines, constant axes, saturation
    add_pair(24'd0, 24'd0, 1'b1);
    add_pair(SMAX, SMAX, 1'b1);
    add_pair(24'd0, 24'd0, 1'b0);
    add_pair(SMAX, SMAX, 1'b1);
    add_pair(24'd0, SMAX, 1'b0);
    add_pair(SMAX, 24'd0, 1'b1);
    add_pair(24'd3, 24'd1, 1'b0);
    add_pair(24'd3, 24'd9, 1'b1);
    add_pair(24'd0, 24'd5, 1'b0);
    add_pair(24'd7, 24'd5, 1'b1);
    add_pair(SMAX, 24'd0, 1'b0);
    add_pair(SMAX - 24'd1, SMAX, 1'b1);
    add_pair(SMAX - 24'd1, 24'd0, 1'b0);
    add_pair(SMAX, SMAX, 1'b1);
    add_pair(24'd1, 24'd2, 1'b0);
    add_pair(24'd2, 24'd4, 1'b0);
    add_pair(24'd3, 24'd7, 1'b1);
    add_pair(24'h555555, 24'hAAAAAA, 1'b0);
    add_pair(24'hAAAAAA, 24'h555555, 1'b0);
    add_pair(24'h123456, 24'h654321, 1'b1);
    total = pending_pairs.size();
    // random sets, mostly short, now and then a longer one
    while (total < 700) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(9, 40))
                                        : int'($urandom_range(1, 8));
      add_random_set(len);
      total += len;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_pairs.size() < 60);
    calm = 1'b1;
    wait (pending_pairs.size() == 0 && !s_axis_tvalid_i);
    wait (expected_fits.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("least_squares_line_fit_core regression: pass");
    end else begin
      $display("least_squares_line_fit_core regression: fail");
    end
    $finish;
  end
endmodule
